/* hdl/stream_pattern_substitute_macros.svh */
// Assertion macros shared by the stream_pattern_substitute RTL.
`ifndef STREAM_PATTERN_SUBSTITUTE_MACROS_SVH
`define STREAM_PATTERN_SUBSTITUTE_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk, ignoring cycles in reset.
`define SPS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stream_pattern_substitute: assertion failed");

// Check prop at every rising edge of clk, reset included.
`define SPS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("stream_pattern_substitute: assertion failed");

`else

`define SPS_ASSERT(name, clk, rst, prop)
`define SPS_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

/* hdl/sps_pkg.sv */
`timescale 1ns / 1ps

package sps_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 4;
  localparam int COUNT_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES     = 3'd0,
    CFG_PATTERN_LEN       = 3'd1,
    CFG_REPLACEMENT_BYTES = 3'd2,
    CFG_REPLACEMENT_LEN   = 3'd3,
    CFG_INSTANCE_SELECT   = 3'd4
  } cfg_reg_t;

  // Flags that travel with one group of emitted bytes.
  typedef struct packed {
    logic no_data;
    logic text_end;
  } run_ctl_t;

endpackage

/* hdl/sps_match.sv */
`timescale 1ns / 1ps
`include "stream_pattern_substitute_macros.svh"

module sps_match import sps_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8,
  parameter int RUN_DEPTH       = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                  : MAX_REPLACEMENT,
  parameter int RUN_W           = $clog2(RUN_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  input  logic [BYTE_W-1:0]     step_byte,
  input  logic                  step_last,
  output logic [BYTE_W-1:0]     emit_bytes [RUN_DEPTH],
  output logic [RUN_W-1:0]      emit_cnt,
  output run_ctl_t              emit_ctl
);

  localparam int PL_W = $clog2(MAX_PATTERN + 1);
  localparam int RL_W = $clog2(MAX_REPLACEMENT + 1);

  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_len;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_W-1:0]      replacement_len;
  logic [COUNT_W-1:0]    instance_select;

  logic [BYTE_W-1:0]  window [MAX_PATTERN];
  logic [BYTE_W-1:0]  window_next [MAX_PATTERN];
  logic [PL_W-1:0]    wc;
  logic [PL_W-1:0]    wc_next;
  logic [COUNT_W-1:0] occ;
  logic [COUNT_W-1:0] occ_next;

  logic [PL_W-1:0]    plen;
  logic [RL_W-1:0]    rlen;
  logic [PL_W-1:0]    cnt1;
  logic [BYTE_W-1:0]  w [MAX_PATTERN];
  logic               full;
  logic               hit;
  logic [COUNT_W-1:0] occ_inc;
  logic               pick;
  logic               use_rep;
  logic               shift;
  logic               empty_end;
  logic [RUN_W-1:0]   n;

  always_comb begin
    plen = (pattern_len > LEN_W'(MAX_PATTERN)) ? PL_W'(MAX_PATTERN) : PL_W'(pattern_len);
    rlen = (replacement_len > LEN_W'(MAX_REPLACEMENT)) ? RL_W'(MAX_REPLACEMENT)
                                                       : RL_W'(replacement_len);
    cnt1 = wc + PL_W'(1);

    // Window with the new byte written at the fill position.
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w[i] = (PL_W'(i) == wc) ? step_byte : window[i];
    end

    full = (plen != '0) && (cnt1 == plen);
    hit  = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((PL_W'(i) < plen) && (w[i] != pattern_bytes[i*BYTE_W +: BYTE_W])) begin
        hit = 1'b0;
      end
    end

    occ_inc = (occ == COUNT_MAX) ? occ : occ + COUNT_W'(1);
    pick    = (instance_select == '0) || (occ_inc == instance_select);

    use_rep  = 1'b0;
    shift    = 1'b0;
    n        = '0;
    wc_next  = wc;
    occ_next = occ;
    priority if (plen == '0) begin
      n       = RUN_W'(1);
      wc_next = '0;
    end else if (full && hit) begin
      occ_next = occ_inc;
      wc_next  = '0;
      use_rep  = pick;
      n        = pick ? RUN_W'(rlen) : RUN_W'(plen);
    end else if (full) begin
      // Mismatch: emit the oldest byte, or flush everything on the last byte.
      shift   = !step_last;
      n       = step_last ? RUN_W'(plen) : RUN_W'(1);
      wc_next = plen - PL_W'(1);
    end else begin
      wc_next = cnt1;
      n       = step_last ? RUN_W'(cnt1) : '0;
    end

    if (step_last) begin
      wc_next  = '0;
      occ_next = '0;
    end

    empty_end = step_last && (n == '0);

    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      window_next[i] = shift ? w[i+1] : w[i];
    end
    window_next[MAX_PATTERN-1] = w[MAX_PATTERN-1];

    for (int i = 0; i < RUN_DEPTH; i++) begin
      emit_bytes[i] = '0;
    end
    if (!empty_end) begin
      if (use_rep) begin
        for (int i = 0; i < MAX_REPLACEMENT; i++) begin
          emit_bytes[i] = replacement_bytes[i*BYTE_W +: BYTE_W];
        end
      end else begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          emit_bytes[i] = w[i];
        end
      end
    end

    emit_cnt          = empty_end ? RUN_W'(1) : n;
    emit_ctl.no_data  = empty_end;
    emit_ctl.text_end = step_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len     <= '0;
      replacement_len <= '0;
      instance_select <= '0;
      wc              <= '0;
      occ             <= '0;
    end else begin
      if (step) begin
        wc  <= wc_next;
        occ <= occ_next;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_PATTERN_LEN: begin
            pattern_len <= cfg_data[LEN_W-1:0];
            wc          <= '0;
          end
          CFG_REPLACEMENT_LEN: replacement_len <= cfg_data[LEN_W-1:0];
          CFG_INSTANCE_SELECT: instance_select <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pattern and replacement bytes reset to zero like the other configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      replacement_bytes <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PATTERN_BYTES:     pattern_bytes     <= cfg_data;
        CFG_REPLACEMENT_BYTES: replacement_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      window <= window_next;
    end
  end

  `SPS_ASSERT(a_wc_idle_without_pattern, clk, rst, (plen == PL_W'(0)) |-> (wc == PL_W'(0)))
  `SPS_ASSERT(a_wc_below_len, clk, rst, (plen != PL_W'(0)) |-> (wc < plen))
  `SPS_ASSERT(a_empty_only_at_end, clk, rst, (step && emit_ctl.no_data) |-> step_last)

endmodule

/* hdl/stream_pattern_substitute.sv */
`timescale 1ns / 1ps
`include "stream_pattern_substitute_macros.svh"
// Path: a text byte enters the input register, then its results load into the output shifter.
// Throughput: one text byte per cycle while out_stall is low and each byte yields at most one
// result; a byte with more results holds the input until the one-byte-per-cycle output shifter
// drains them. One text byte waits in the input register while results drain. Synchronous
// reset (rst): held flag, run count and config registers zero; window, occurrence count empty.

module stream_pattern_substitute import sps_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  text_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  no_data,
  output logic                  run_last,
  output logic                  text_end
);

  localparam int RUN_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int RUN_W     = $clog2(RUN_DEPTH + 1);

  logic              held;
  logic [BYTE_W-1:0] held_byte;
  logic              held_last;

  logic [BYTE_W-1:0] run_bytes [RUN_DEPTH];
  logic [RUN_W-1:0]  run_cnt;
  run_ctl_t          run_ctl;

  logic [BYTE_W-1:0] emit_bytes [RUN_DEPTH];
  logic [RUN_W-1:0]  emit_cnt;
  run_ctl_t          emit_ctl;

  logic in_take;
  logic out_take;
  logic run_done;
  logic load;

  assign cfg_ready = 1'b1;

  assign out_valid = (run_cnt != '0);
  assign out_byte  = run_bytes[0];
  assign no_data   = run_ctl.no_data;
  assign run_last  = (run_cnt == RUN_W'(1));
  assign text_end  = run_last && run_ctl.text_end;

  assign out_take   = out_valid && !out_stall;
  assign run_done   = out_take && run_last;
  // Process the held byte once the result shifter is empty or drains this cycle.
  assign load       = held && (!out_valid || run_done);
  assign text_stall = held && !load;
  assign in_take    = text_valid && !text_stall;

  sps_match #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .RUN_DEPTH       (RUN_DEPTH),
    .RUN_W           (RUN_W)
  ) u_match (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .step       (load),
    .step_byte  (held_byte),
    .step_last  (held_last),
    .emit_bytes (emit_bytes),
    .emit_cnt   (emit_cnt),
    .emit_ctl   (emit_ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      run_cnt <= '0;
    end else begin
      if (in_take) begin
        held <= 1'b1;
      end else if (load) begin
        held <= 1'b0;
      end
      if (load) begin
        run_cnt <= emit_cnt;
      end else if (out_take) begin
        run_cnt <= run_cnt - RUN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_byte <= text_byte;
      held_last <= text_last;
    end
    if (load) begin
      run_bytes <= emit_bytes;
      run_ctl   <= emit_ctl;
    end else if (out_take) begin
      // Advance to the next byte of the run.
      for (int i = 0; i < RUN_DEPTH - 1; i++) begin
        run_bytes[i] <= run_bytes[i+1];
      end
    end
  end

  `SPS_ASSERT(a_stall_only_when_held, clk, rst, text_stall |-> held)
  `SPS_ASSERT(a_run_fits, clk, rst, run_cnt <= RUN_W'(RUN_DEPTH))
  `SPS_ASSERT(a_end_mark_clean, clk, rst,
              (out_valid && no_data) |-> (out_byte == '0 && text_end))

endmodule
